// File: rtl/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg: shared types and constants of the paletted mipmap downsampler
// Field widths, palette and line sizes, the search word that moves down the
// cell row, and the codes of the input action and of the registers.
// ----------------------------------------------------------------------------
package pmd_pkg;

  // Sizes
  localparam int MAX_WIDTH       = 1024;
  localparam int MAX_HEIGHT      = 1024;
  localparam int PALETTE_ENTRIES = 256;

  // Field widths
  localparam int PIX_W     = 8;
  localparam int CHAN_W    = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 4;

  // Derived widths
  localparam int LUT_AW   = $clog2(PALETTE_ENTRIES);
  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int W_W      = $clog2(MAX_WIDTH + 1);
  localparam int H_W      = $clog2(MAX_HEIGHT + 1);
  localparam int W_CMP_W  = (CFG_W > W_W) ? CFG_W : W_W;
  localparam int H_CMP_W  = (CFG_W > H_W) ? CFG_W : H_W;
  localparam int SLOT_NUM = MAX_WIDTH / 2;
  localparam int SLOT_W   = $clog2(SLOT_NUM);
  localparam int SUM_W    = CHAN_W + 1;
  localparam int AVG_W    = CHAN_W + 2;
  localparam int DIST_W   = CHAN_W + 2;

  // Start distance of a search; every real L1 distance is below it
  localparam logic [DIST_W-1:0] NO_MATCH_DIST = {DIST_W{1'b1}};

  // Register reset values
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(256);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(256);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = CFG_IDX_W'(1);

  // Input action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  // Word handed from cell to cell: a palette load or a nearest-color search.
  // For a load, idx is the entry written; for a search, the best index so far.
  typedef struct packed {
    logic              is_load;
    logic              last;
    rgb_t              colour;
    logic [PIX_W-1:0]  idx;
    logic [DIST_W-1:0] best_dist;
  } token_t;

endpackage

// File: rtl/pmd_ifs.sv
// ----------------------------------------------------------------------------
// pmd interfaces: input, result and register-write channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pmd_in_if import pmd_pkg::*;;
  logic              valid;
  logic              ready;
  logic              action;
  logic [PIX_W-1:0]  entry_index;
  logic [CHAN_W-1:0] entry_red;
  logic [CHAN_W-1:0] entry_green;
  logic [CHAN_W-1:0] entry_blue;
  logic [PIX_W-1:0]  source_pixel;

  modport source (output valid, action, entry_index, entry_red, entry_green,
                  entry_blue, source_pixel, input ready);
  modport sink (input valid, action, entry_index, entry_red, entry_green,
                entry_blue, source_pixel, output ready);
endinterface

interface pmd_out_if import pmd_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] reduced_pixel;
  logic             frame_last;

  modport source (output valid, reduced_pixel, frame_last, input ready);
  modport sink (input valid, reduced_pixel, frame_last, output ready);
endinterface

interface pmd_cfg_if import pmd_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/pmd_front.sv
// ----------------------------------------------------------------------------
// pmd_front: pixel lookup and 2x2 block summing
// Holds the size registers and raster counters, the palette lookup memory
// and the line of horizontal pair sums; emits one word per load and one
// search word per finished 2x2 block, in input order.
// ----------------------------------------------------------------------------
module pmd_front import pmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic                 in_action,
  input  logic [PIX_W-1:0]     in_entry_index,
  input  rgb_t                 in_entry_colour,
  input  logic [PIX_W-1:0]     in_source_pixel,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 tok_valid,
  output token_t               tok
);

  rgb_t lut_mem [PALETTE_ENTRIES];
  sum_t pair_mem [SLOT_NUM];

  logic [CFG_W-1:0] width_r, height_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;

  logic [W_W-1:0]   w_use, col_p1;
  logic [H_W-1:0]   h_use, row_p1;
  logic             accept, in_range;

  // stage A
  logic              a_valid_r, a_load_r, a_col_odd_r, a_row_odd_r, a_last_r;
  logic              a_black_r;
  logic [SLOT_W-1:0] a_slot_r;
  logic [PIX_W-1:0]  a_idx_r;
  rgb_t              a_colour_r, lut_rd_r, px, held_left_r;
  sum_t              pair_sum;

  // stage B
  logic              b_valid_r, b_load_r, b_last_r;
  logic [PIX_W-1:0]  b_idx_r;
  rgb_t              b_colour_r;
  sum_t              sums_r, pair_rd_r;
  logic [AVG_W-1:0]  avg_red, avg_green, avg_blue;

  // Clamp the sizes, force even, floor at two
  always_comb begin
    logic [W_CMP_W-1:0] wv;
    logic [H_CMP_W-1:0] hv;
    wv = W_CMP_W'(width_r);
    if (wv > W_CMP_W'(MAX_WIDTH)) wv = W_CMP_W'(MAX_WIDTH);
    wv[0] = 1'b0;
    if (wv < W_CMP_W'(2)) wv = W_CMP_W'(2);
    hv = H_CMP_W'(height_r);
    if (hv > H_CMP_W'(MAX_HEIGHT)) hv = H_CMP_W'(MAX_HEIGHT);
    hv[0] = 1'b0;
    if (hv < H_CMP_W'(2)) hv = H_CMP_W'(2);
    w_use = W_W'(wv);
    h_use = H_W'(hv);
  end

  assign accept   = in_valid && adv;
  assign in_range = (PIX_W + 1)'(in_entry_index) < (PIX_W + 1)'(PALETTE_ENTRIES);
  assign col_p1   = W_W'(col_r) + W_W'(1);
  assign row_p1   = H_W'(row_r) + H_W'(1);

  // Size registers and raster position; a write to either size register restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH: begin
          width_r <= cfg_data;
          col_r   <= '0;
          row_r   <= '0;
        end
        REG_SOURCE_HEIGHT: begin
          height_r <= cfg_data;
          col_r    <= '0;
          row_r    <= '0;
        end
        default: ;
      endcase
    end else if (accept && in_action == ACT_PIXEL) begin
      if (col_p1 >= w_use) begin
        col_r <= '0;
        if (row_p1 >= h_use) begin
          row_r <= '0;
        end else begin
          row_r <= row_p1[ROW_W-1:0];
        end
      end else begin
        col_r <= col_p1[COL_W-1:0];
      end
    end
  end

  // Stage A: palette write or lookup read
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_action == ACT_LOAD) begin
        if (in_range) lut_mem[in_entry_index[LUT_AW-1:0]] <= in_entry_colour;
      end else begin
        lut_rd_r <= lut_mem[in_source_pixel[LUT_AW-1:0]];
      end
      a_load_r    <= (in_action == ACT_LOAD);
      a_black_r   <= (PIX_W + 1)'(in_source_pixel) >= (PIX_W + 1)'(PALETTE_ENTRIES);
      a_col_odd_r <= col_r[0];
      a_row_odd_r <= row_r[0];
      a_slot_r    <= SLOT_W'(col_r >> 1);
      a_last_r    <= (col_p1 == w_use) && (row_p1 == h_use);
      a_idx_r     <= in_entry_index;
      a_colour_r  <= in_entry_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r && (a_load_r || (a_col_odd_r && a_row_odd_r));
    end
  end

  assign px = a_black_r ? '0 : lut_rd_r;

  always_comb begin
    pair_sum.red   = SUM_W'(held_left_r.red) + SUM_W'(px.red);
    pair_sum.green = SUM_W'(held_left_r.green) + SUM_W'(px.green);
    pair_sum.blue  = SUM_W'(held_left_r.blue) + SUM_W'(px.blue);
  end

  // Stage B: hold the left pixel, store or fetch the pair sums of the slot
  always_ff @(posedge clk) begin
    if (adv && a_valid_r) begin
      if (!a_load_r) begin
        if (!a_col_odd_r) begin
          held_left_r <= px;
        end else if (!a_row_odd_r) begin
          pair_mem[a_slot_r] <= pair_sum;
        end else begin
          pair_rd_r <= pair_mem[a_slot_r];
        end
      end
      sums_r     <= pair_sum;
      b_load_r   <= a_load_r;
      b_last_r   <= a_last_r;
      b_idx_r    <= a_idx_r;
      b_colour_r <= a_colour_r;
    end
  end

  assign avg_red   = AVG_W'(sums_r.red) + AVG_W'(pair_rd_r.red);
  assign avg_green = AVG_W'(sums_r.green) + AVG_W'(pair_rd_r.green);
  assign avg_blue  = AVG_W'(sums_r.blue) + AVG_W'(pair_rd_r.blue);

  always_comb begin
    tok_valid     = b_valid_r;
    tok.is_load   = b_load_r;
    tok.last      = b_last_r;
    tok.best_dist = NO_MATCH_DIST;
    if (b_load_r) begin
      tok.colour = b_colour_r;
      tok.idx    = b_idx_r;
    end else begin
      // truncating divide by four
      tok.colour.red   = avg_red[AVG_W-1:2];
      tok.colour.green = avg_green[AVG_W-1:2];
      tok.colour.blue  = avg_blue[AVG_W-1:2];
      tok.idx          = '0;
    end
  end

endmodule

// File: rtl/pmd_cell.sv
// ----------------------------------------------------------------------------
// pmd_cell: one palette entry of the search row
// Keeps one palette color, takes a load word aimed at it, and on a search
// word replaces the best index when its own color is strictly nearer.
// ----------------------------------------------------------------------------
module pmd_cell import pmd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic [PIX_W-1:0] cell_idx,
  input  logic             in_valid,
  input  token_t           in_tok,
  output logic             out_valid,
  output token_t           out_tok
);

  rgb_t              entry_r;
  logic              valid_r;
  token_t            tok_r, tok_nxt;
  logic [CHAN_W-1:0] ad_red, ad_green, ad_blue;
  logic [DIST_W-1:0] cell_dist;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign ad_red    = abs_diff(in_tok.colour.red, entry_r.red);
  assign ad_green  = abs_diff(in_tok.colour.green, entry_r.green);
  assign ad_blue   = abs_diff(in_tok.colour.blue, entry_r.blue);
  assign cell_dist = DIST_W'(ad_red) + DIST_W'(ad_green) + DIST_W'(ad_blue);

  always_comb begin
    tok_nxt = in_tok;
    // strict compare: lower index keeps a tie
    if (!in_tok.is_load && cell_dist < in_tok.best_dist) begin
      tok_nxt.best_dist = cell_dist;
      tok_nxt.idx       = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
      if (in_valid && in_tok.is_load && in_tok.idx == cell_idx) begin
        entry_r <= in_tok.colour;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;

endmodule

// File: rtl/pmd_chain.sv
// ----------------------------------------------------------------------------
// pmd_chain: row of palette cells
// One cell per palette entry; words step one cell per advancing cycle, so
// loads and searches keep their order all the way down the row.
// ----------------------------------------------------------------------------
module pmd_chain import pmd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   in_valid,
  input  token_t in_tok,
  output logic   out_valid,
  output token_t out_tok
);

  logic   link_valid [PALETTE_ENTRIES + 1];
  token_t link_tok   [PALETTE_ENTRIES + 1];

  assign link_valid[0] = in_valid;
  assign link_tok[0]   = in_tok;

  for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
    pmd_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .cell_idx  (PIX_W'(k)),
      .in_valid  (link_valid[k]),
      .in_tok    (link_tok[k]),
      .out_valid (link_valid[k+1]),
      .out_tok   (link_tok[k+1])
    );
  end

  assign out_valid = link_valid[PALETTE_ENTRIES];
  assign out_tok   = link_tok[PALETTE_ENTRIES];

endmodule

// File: rtl/paletted_mipmap_downsampler_unit.sv
// ----------------------------------------------------------------------------
// paletted_mipmap_downsampler_unit: 2x2 box filter with nearest palette color
// Loads a palette, then reduces one mip level of an indexed image and
// returns, per 2x2 block, the palette index nearest the average color.
// ----------------------------------------------------------------------------
//
//   channel  dir  word                                           accepted when
//   in_ch    in   action, entry_index, entry_rgb, source_pixel   valid & ready
//   out_ch   out  reduced_pixel, frame_last                      valid & ready
//   cfg_ch   in   index, data (source_width, source_height)      valid & ready
//
// One input word a cycle; the result of a block goes from its closing pixel through stage
// A, stage B, the row of one cell per palette entry and the output register.
// The whole pipe holds only when a result reaches the row's end while the
// output register is still full; loads and bubbles keep moving otherwise.
// Synchronous active-low reset clears control only; no clearing pass runs,
// and the palette must be loaded before pixels that use it.
// ----------------------------------------------------------------------------
module paletted_mipmap_downsampler_unit import pmd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  pmd_in_if.sink    in_ch,
  pmd_out_if.source out_ch,
  pmd_cfg_if.sink   cfg_ch
);

  logic             adv, front_valid, tail_valid, tail_query;
  token_t           front_tok, tail_tok;
  rgb_t             entry_colour;
  logic             out_valid_r;
  logic [PIX_W-1:0] reduced_pixel_r;
  logic             frame_last_r;

  assign tail_query = tail_valid && !tail_tok.is_load;
  // hold everything only when a finished search has nowhere to go
  assign adv        = !(tail_query && out_valid_r && !out_ch.ready);

  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;

  assign entry_colour.red   = in_ch.entry_red;
  assign entry_colour.green = in_ch.entry_green;
  assign entry_colour.blue  = in_ch.entry_blue;

  pmd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_ch.valid),
    .in_action       (in_ch.action),
    .in_entry_index  (in_ch.entry_index),
    .in_entry_colour (entry_colour),
    .in_source_pixel (in_ch.source_pixel),
    .cfg_write       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .tok_valid       (front_valid),
    .tok             (front_tok)
  );

  pmd_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (front_valid),
    .in_tok    (front_tok),
    .out_valid (tail_valid),
    .out_tok   (tail_tok)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tail_query && adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_query && adv) begin
      reduced_pixel_r <= tail_tok.idx;
      frame_last_r    <= tail_tok.last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.reduced_pixel = reduced_pixel_r;
  assign out_ch.frame_last    = frame_last_r;

endmodule

// File: tb/pmd_tb_pkg.sv
// ----------------------------------------------------------------------------
// pmd_tb_pkg: prediction and result checking for the mipmap downsampler test
// Keeps its own palette, upper-row pair sums and frame position, works out
// the nearest palette index for every closed 2x2 block and checks the words
// that leave the block against that queue in order.
// ----------------------------------------------------------------------------
package pmd_tb_pkg;
  import pmd_pkg::*;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] entry_index;
    rgb_t             entry;
    logic [PIX_W-1:0] source_pixel;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] reduced_pixel;
    logic             frame_last;
  } reduced_t;

  class block_average_tracker;
    rgb_t             palette [PALETTE_ENTRIES];
    sum_t             upper_pairs [SLOT_NUM];
    rgb_t             left_colour;
    int unsigned      col;
    int unsigned      row;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    reduced_t         reduced_q [$];
    int unsigned      errors;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      errors     = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      col         = 0;
      row         = 0;
      left_colour = '0;
    endfunction

    // Clamp to the limit, round down to even, floor of 2
    function int unsigned used_size(logic [CFG_W-1:0] reg_value, int unsigned limit);
      int unsigned s;
      s = (reg_value > limit) ? limit : reg_value;
      s = s - (s % 2);
      return (s < 2) ? 2 : s;
    endfunction

    function int chan_diff(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Lowest index wins a tie: only a strictly smaller distance replaces
    function logic [PIX_W-1:0] nearest_index(int r, int g, int b);
      int               best_dist;
      int               d;
      logic [PIX_W-1:0] best;
      best_dist = int'(NO_MATCH_DIST) + 1;
      best      = '0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        d = chan_diff(r, int'(palette[i].red)) + chan_diff(g, int'(palette[i].green)) +
            chan_diff(b, int'(palette[i].blue));
        if (d < best_dist) begin
          best_dist = d;
          best      = PIX_W'(i);
        end
      end
      return best;
    endfunction

    function void write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_SOURCE_WIDTH) begin
        width_reg = data;
        restart_frame();
      end else if (idx == REG_SOURCE_HEIGHT) begin
        height_reg = data;
        restart_frame();
      end
    endfunction

    function void take_word(in_word_t word);
      rgb_t        colour;
      sum_t        pair;
      sum_t        above;
      reduced_t    res;
      int unsigned w_used;
      int unsigned h_used;
      int unsigned slot;
      if (word.action == ACT_LOAD) begin
        palette[word.entry_index] = word.entry;
        return;
      end
      w_used = used_size(width_reg, MAX_WIDTH);
      h_used = used_size(height_reg, MAX_HEIGHT);
      colour = palette[word.source_pixel];
      slot   = col / 2;
      if (col % 2 == 0) begin
        left_colour = colour;
      end else begin
        pair.red   = SUM_W'(left_colour.red) + SUM_W'(colour.red);
        pair.green = SUM_W'(left_colour.green) + SUM_W'(colour.green);
        pair.blue  = SUM_W'(left_colour.blue) + SUM_W'(colour.blue);
        if (row % 2 == 0) begin
          upper_pairs[slot] = pair;
        end else begin
          above = upper_pairs[slot];
          res.reduced_pixel = nearest_index((int'(pair.red) + int'(above.red)) / 4,
                                            (int'(pair.green) + int'(above.green)) / 4,
                                            (int'(pair.blue) + int'(above.blue)) / 4);
          res.frame_last = (col + 1 == w_used) && (row + 1 == h_used);
          reduced_q.push_back(res);
        end
      end
      col++;
      if (col >= w_used) begin
        col = 0;
        row++;
        if (row >= h_used) row = 0;
      end
    endfunction

    function int unsigned pending();
      return reduced_q.size();
    endfunction

    function void compare_result(reduced_t got);
      reduced_t want;
      if (reduced_q.size() == 0) begin
        $error("unexpected word: reduced_pixel %0d frame_last %0d",
               got.reduced_pixel, got.frame_last);
        errors++;
        return;
      end
      want = reduced_q.pop_front();
      if (got.reduced_pixel !== want.reduced_pixel) begin
        $error("reduced_pixel mismatch: expected %0d, actual %0d",
               want.reduced_pixel, got.reduced_pixel);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last mismatch: expected %0d, actual %0d",
               want.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/paletted_mipmap_downsampler_unit_test.sv
// ----------------------------------------------------------------------------
// paletted_mipmap_downsampler_unit_test: self-checking test of the downsampler
// Loads a full palette, runs short hand-picked blocks on the smallest frame,
// then random pixel streams with palette reloads over a range of frame sizes,
// including clamped, odd and widest settings, with random gaps on both sides
// and one long output hold that backs the pipe up into the input.
// ----------------------------------------------------------------------------
module paletted_mipmap_downsampler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pmd_pkg::*;
  import pmd_tb_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int PIPE_CYCLES    = PALETTE_ENTRIES + 3;
  localparam int SETTLE_CYCLES  = PIPE_CYCLES + 8;
  localparam int LONG_HOLD      = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_GAP        = 11;

  // Indexes past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_TOP = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  pmd_in_if  in_ch ();
  pmd_out_if out_ch ();
  pmd_cfg_if cfg_ch ();

  block_average_tracker tracker = new();

  bit          src_steady  = 1'b0;
  bit          sink_steady = 1'b0;
  bit          hold_armed  = 1'b0;
  int unsigned idle_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  paletted_mipmap_downsampler_unit u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  function automatic rgb_t random_colour();
    rgb_t colour;
    // Coarse grid values repeat often, which produces distance ties
    if ($urandom_range(0, 1) == 0) begin
      colour.red   = 8'(85 * $urandom_range(0, 3));
      colour.green = 8'(85 * $urandom_range(0, 3));
      colour.blue  = 8'(85 * $urandom_range(0, 3));
    end else begin
      colour = {8'($urandom), 8'($urandom), 8'($urandom)};
    end
    return colour;
  endfunction

  function automatic in_word_t make_load(logic [PIX_W-1:0] idx, rgb_t colour);
    in_word_t word;
    word.action       = ACT_LOAD;
    word.entry_index  = idx;
    word.entry        = colour;
    word.source_pixel = PIX_W'($urandom);
    return word;
  endfunction

  task automatic send_word(input in_word_t word);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
    gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= word.action;
    in_ch.entry_index  <= word.entry_index;
    in_ch.entry_red    <= word.entry.red;
    in_ch.entry_green  <= word.entry.green;
    in_ch.entry_blue   <= word.entry.blue;
    in_ch.source_pixel <= word.source_pixel;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.take_word(word);
  endtask

  // Unused load fields carry noise
  task automatic send_pixel(logic [PIX_W-1:0] pix);
    in_word_t word;
    word.action       = ACT_PIXEL;
    word.entry_index  = PIX_W'($urandom);
    word.entry        = {8'($urandom), 8'($urandom), 8'($urandom)};
    word.source_pixel = pix;
    send_word(word);
  endtask

  task automatic load_palette();
    rgb_t colour;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      if (i == 0) colour = '0;
      else if (i == PALETTE_ENTRIES - 1) colour = '1;
      else colour = random_colour();
      send_word(make_load(PIX_W'(i), colour));
    end
  endtask

  task automatic run_pixels(int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) send_word(make_load(PIX_W'($urandom), random_colour()));
      send_pixel(PIX_W'($urandom));
    end
  endtask

  // Wait out every expected word, then the pipe depth for pixels that close no block
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tracker.write_config(idx, data);
  endtask

  task automatic set_frame(logic [CFG_W-1:0] width, logic [CFG_W-1:0] height);
    drain();
    write_reg(REG_SOURCE_WIDTH, width);
    write_reg(REG_SOURCE_HEIGHT, height);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_LOAD;
    in_ch.entry_index  <= '0;
    in_ch.entry_red    <= '0;
    in_ch.entry_green  <= '0;
    in_ch.entry_blue   <= '0;
    in_ch.source_pixel <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_SOURCE_WIDTH;
    cfg_ch.data        <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    load_palette();

    // Smallest frame: one 2x2 block, so every word closes the frame
    set_frame('0, CFG_W'(1));
    send_pixel('0);
    send_pixel('1);
    send_pixel('1);
    send_pixel('0);
    repeat (4) send_pixel('1);
    // Reload an entry between pixels of one block
    send_pixel('0);
    send_word(make_load(PIX_W'(1), {8'd10, 8'd20, 8'd30}));
    send_pixel(PIX_W'(1));
    send_pixel(PIX_W'(1));
    send_pixel('0);
    send_pixel(PIX_W'(254));
    send_pixel(PIX_W'(1));
    send_pixel(PIX_W'(128));
    send_pixel(PIX_W'(127));

    // Full frame and a wrap; back the output up once along the way
    set_frame(CFG_W'(8), CFG_W'(8));
    hold_armed = 1'b1;
    run_pixels(70);
    set_frame(CFG_W'(9), CFG_W'(13));
    run_pixels(40);
    set_frame(CFG_W'(22), CFG_W'(6));
    run_pixels(40);
    // Widest row, clamped from the top of the register range
    set_frame('1, CFG_W'(2));
    run_pixels(30);
    set_frame('0, CFG_W'(MAX_HEIGHT));
    run_pixels(20);
    // Writes past the register list leave the frame running
    drain();
    write_reg(REG_UNUSED_TOP, '1);
    write_reg(REG_UNUSED_LOW, CFG_W'(8));
    cfg_ch.valid <= 1'b0;
    run_pixels(30);
    set_frame(CFG_W'(12), CFG_W'(1030));
    run_pixels(24);

    drain();
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned gap;
    reduced_t    got;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_armed) begin
        hold_armed = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
      gap = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.reduced_pixel = out_ch.reduced_pixel;
      got.frame_last    = out_ch.frame_last;
      tracker.compare_result(got);
    end
  end

  // Abort when no channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: files.f
rtl/pmd_pkg.sv
rtl/pmd_ifs.sv
rtl/pmd_front.sv
rtl/pmd_cell.sv
rtl/pmd_chain.sv
rtl/paletted_mipmap_downsampler_unit.sv
tb/pmd_tb_pkg.sv
tb/paletted_mipmap_downsampler_unit_test.sv
